// File: src/crr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_pkg: shared types, constants and arithmetic for the Roessler ring.
// Holds the site entry layout, the configuration group, the memory request
// and the saturating Q16.16 helpers used by the integration engine.
// ----------------------------------------------------------------------------
package crr_pkg;

  // Value format and store geometry.
  localparam int VW    = 32;
  localparam int SITES = 1024;
  localparam int AW    = 10;

  typedef logic signed [VW-1:0] value_t;

  localparam value_t VMAX = 32'sh7FFF_FFFF;
  localparam value_t VMIN = 32'sh8000_0000;

  // Ring length limits.
  localparam logic [10:0] LEN_MIN = 11'd3;
  localparam logic [10:0] LEN_MAX = 11'd1024;

  // Rounding and division by six through a reciprocal.
  localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0000_8000;
  localparam logic [31:0] RECIP6     = 32'hAAAA_AAAB;
  localparam logic [31:0] R6_BIAS    = 32'd3;

  // Configuration register reset values.
  localparam logic [23:0] RST_COEFF_A  = 24'd13107;
  localparam logic [23:0] RST_COEFF_B  = 24'd65536;
  localparam logic [23:0] RST_COEFF_C  = 24'd589824;
  localparam logic [23:0] RST_COUPLING = 24'd65536;
  localparam logic [16:0] RST_DT       = 17'd655;
  localparam logic [15:0] RST_STEPS    = 16'd1;
  localparam logic [10:0] RST_LEN      = 11'd1024;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_RUN  = 2'd1,
    FUNC_READ = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    REG_COEFF_A    = 3'd0,
    REG_COEFF_B    = 3'd1,
    REG_COEFF_C    = 3'd2,
    REG_COUPLING_D = 3'd3,
    REG_TIME_STEP  = 3'd4,
    REG_STEP_COUNT = 3'd5,
    REG_RING_LEN   = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE_LAST, S_PRE_FIRST, S_LOAD, S_LAP, S_DY, S_DX, S_DZ,
    S_INC, S_MUL_DT, S_QDT, S_MUL_R6, S_R6, S_WRITE
  } eng_state_t;

  typedef struct packed {
    value_t z;
    value_t y;
    value_t x;
  } triple_t;

  // One memory word per site: oscillator state, stage point, increment sum.
  typedef struct packed {
    triple_t inc;
    triple_t stg;
    triple_t osc;
  } entry_t;

  typedef struct packed {
    logic inc;
    logic stg;
    logic osc;
  } lane_t;

  typedef struct packed {
    logic          re;
    logic [AW-1:0] raddr;
    lane_t         we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
  } mem_req_t;

  typedef struct packed {
    value_t      a;
    value_t      b;
    value_t      c;
    value_t      d;
    logic [16:0] dt;
    logic [15:0] steps;
    logic [10:0] len;
  } cfg_t;

  typedef struct packed {
    value_t val;
    logic   clamp;
  } sat_t;

  function automatic sat_t sat_add(value_t a, value_t b);
    logic signed [VW:0] s;
    sat_t r;
    s = {a[VW-1], a} + {b[VW-1], b};
    r.clamp = (s[VW] != s[VW-1]);
    r.val = r.clamp ? (s[VW] ? VMIN : VMAX) : s[VW-1:0];
    return r;
  endfunction

  function automatic sat_t sat_sub(value_t a, value_t b);
    logic signed [VW:0] s;
    sat_t r;
    s = {a[VW-1], a} - {b[VW-1], b};
    r.clamp = (s[VW] != s[VW-1]);
    r.val = r.clamp ? (s[VW] ? VMIN : VMAX) : s[VW-1:0];
    return r;
  endfunction

  function automatic logic [VW-1:0] abs_mag(value_t v);
    logic [VW-1:0] u;
    u = v;
    return v[VW-1] ? (~u + 32'd1) : u;
  endfunction

  // Finish a product of magnitudes: round at bit 16, saturate, apply sign.
  function automatic sat_t qfin(logic [63:0] p, logic neg);
    logic [63:0] r;
    logic [47:0] q;
    logic [47:0] lim;
    sat_t res;
    r = p + ROUND_HALF;
    q = r[63:16];
    lim = neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
    if (q > lim) begin
      res.clamp = 1'b1;
      res.val = neg ? VMIN : VMAX;
    end else begin
      res.clamp = 1'b0;
      res.val = neg ? (~q[31:0] + 32'd1) : q[31:0];
    end
    return res;
  endfunction

  // Halve with rounding to nearest, ties away from zero.
  function automatic value_t half_round(value_t v);
    logic [VW-1:0] m;
    logic [VW:0] h;
    logic [VW-1:0] q;
    m = abs_mag(v);
    h = {1'b0, m} + 33'd1;
    q = h[VW:1];
    return v[VW-1] ? (~q + 32'd1) : q;
  endfunction

  // Increment sum update for one component, by RK4 stage.
  function automatic sat_t inc_update(value_t inc, value_t k, logic [1:0] stage);
    sat_t s1;
    sat_t s2;
    sat_t r;
    s1 = sat_add(inc, k);
    s2 = sat_add(s1.val, k);
    case (stage)
      2'd0: begin
        r.val = k;
        r.clamp = 1'b0;
      end
      2'd3: r = s1;
      default: begin
        r.val = s2.val;
        r.clamp = s1.clamp | s2.clamp;
      end
    endcase
    return r;
  endfunction

  function automatic value_t tri_get(triple_t t, logic [1:0] j);
    case (j)
      2'd0:    return t.x;
      2'd1:    return t.y;
      default: return t.z;
    endcase
  endfunction

  function automatic triple_t tri_set(triple_t t, logic [1:0] j, value_t v);
    triple_t r;
    r = t;
    case (j)
      2'd0:    r.x = v;
      2'd1:    r.y = v;
      default: r.z = v;
    endcase
    return r;
  endfunction

endpackage

// File: src/crr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_mem: site store.
// One word per site holding the oscillator state, the stage point and the
// increment sum, with a write enable per field group and a registered read.
// ----------------------------------------------------------------------------
module crr_mem (
  input  logic              clk,
  input  crr_pkg::mem_req_t req,
  output crr_pkg::entry_t   rdata
);

  crr_pkg::entry_t store [crr_pkg::SITES];

  // Field-group writes and a registered read.
  always_ff @(posedge clk) begin
    if (req.we.osc) begin
      store[req.waddr].osc <= req.wdata.osc;
    end
    if (req.we.stg) begin
      store[req.waddr].stg <= req.wdata.stg;
    end
    if (req.we.inc) begin
      store[req.waddr].inc <= req.wdata.inc;
    end
    if (req.re) begin
      rdata <= store[req.raddr];
    end
  end

endmodule

// File: src/crr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_mul: shared multiplier.
// Unsigned 32 by 32 product of two magnitudes, registered at the output.
// ----------------------------------------------------------------------------
module crr_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  // The product is registered and ready in the cycle after the operands.
  always_ff @(posedge clk) begin
    prod <= {32'd0, a} * {32'd0, b};
  end

endmodule

// File: src/crr_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_engine: RK4 sequencer for the oscillator ring.
// Walks the ring site by site for each of the four stages, reading each
// site word, forming its derivatives and writing the updated word back.
// ----------------------------------------------------------------------------
module crr_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              run_go,
  input  crr_pkg::cfg_t     cfg,
  input  crr_pkg::entry_t   rdata,
  output crr_pkg::mem_req_t req,
  output logic              busy,
  output logic              saturated
);

  crr_pkg::eng_state_t state, state_next;

  logic [crr_pkg::AW-1:0] site;
  logic [crr_pkg::AW-1:0] len_m1;
  logic [1:0]             stage;
  logic [1:0]             j;
  logic [15:0]            steps_left;
  crr_pkg::entry_t        cur;
  crr_pkg::value_t        xl;
  crr_pkg::value_t        x0;
  crr_pkg::value_t        lap;
  crr_pkg::value_t        tv;
  crr_pkg::value_t        nyz;
  crr_pkg::value_t        qv;
  crr_pkg::triple_t       k;
  crr_pkg::triple_t       incn;
  crr_pkg::triple_t       res;
  logic                   mul_neg;
  logic                   neg_next;
  logic                   flag;
  logic                   clamp_now;
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [63:0]            prod;
  logic [10:0]            len_clamped;

  crr_pkg::triple_t src_cur;
  crr_pkg::triple_t src_rd;
  crr_pkg::value_t  xr;
  crr_pkg::value_t  w_s;
  crr_pkg::value_t  upd;
  crr_pkg::value_t  r6v;
  logic             last;
  crr_pkg::sat_t    lp1, lp2, lp3, tt;
  crr_pkg::sat_t    qf, dyv, n1, n2, dxv, dzv;
  crr_pkg::sat_t    ux, uy, uz, su, su6;

  crr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Stage 0 derives from the oscillator state, later stages from the stage point.
  assign src_cur = (stage == 2'd0) ? cur.osc : cur.stg;
  assign src_rd  = (stage == 2'd0) ? rdata.osc : rdata.stg;
  assign last    = (site == len_m1);
  assign xr      = last ? x0 : src_rd.x;

  // Derivative arithmetic.
  assign lp1 = crr_pkg::sat_add(xl, xr);
  assign lp2 = crr_pkg::sat_add(src_cur.x, src_cur.x);
  assign lp3 = crr_pkg::sat_sub(lp1.val, lp2.val);
  assign tt  = crr_pkg::sat_sub(src_cur.x, cfg.c);
  assign qf  = crr_pkg::qfin(prod, mul_neg);
  assign dyv = crr_pkg::sat_add(src_cur.x, qf.val);
  assign n1  = crr_pkg::sat_sub('0, src_cur.y);
  assign n2  = crr_pkg::sat_sub(n1.val, src_cur.z);
  assign dxv = crr_pkg::sat_add(nyz, qf.val);
  assign dzv = crr_pkg::sat_add(cfg.b, qf.val);

  // Increment sums and state updates.
  assign ux  = crr_pkg::inc_update(cur.inc.x, k.x, stage);
  assign uy  = crr_pkg::inc_update(cur.inc.y, k.y, stage);
  assign uz  = crr_pkg::inc_update(cur.inc.z, k.z, stage);
  assign w_s = crr_pkg::tri_get(cur.osc, j);
  assign upd = (stage == 2'd2) ? qf.val : crr_pkg::half_round(qf.val);
  assign su  = crr_pkg::sat_add(w_s, upd);
  assign r6v = qv[31] ? (~{2'b00, prod[63:34]} + 32'd1) : {2'b00, prod[63:34]};
  assign su6 = crr_pkg::sat_add(w_s, r6v);

  // Ring length limited to the supported range.
  always_comb begin
    if (cfg.len < crr_pkg::LEN_MIN) begin
      len_clamped = crr_pkg::LEN_MIN;
    end else if (cfg.len > crr_pkg::LEN_MAX) begin
      len_clamped = crr_pkg::LEN_MAX;
    end else begin
      len_clamped = cfg.len;
    end
  end

  // State register and sticky saturation flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crr_pkg::S_IDLE;
      flag  <= 1'b0;
    end else begin
      state <= state_next;
      flag  <= flag | clamp_now;
    end
  end

  // Next state, memory requests and multiplier operands.
  always_comb begin
    state_next = state;
    req        = '0;
    mul_a      = '0;
    mul_b      = '0;
    neg_next   = 1'b0;
    clamp_now  = 1'b0;
    case (state)
      crr_pkg::S_IDLE: begin
        if (run_go && cfg.steps != 16'd0) begin
          state_next = crr_pkg::S_PRE_LAST;
        end
      end
      crr_pkg::S_PRE_LAST: begin
        req.re     = 1'b1;
        req.raddr  = len_m1;
        state_next = crr_pkg::S_PRE_FIRST;
      end
      crr_pkg::S_PRE_FIRST: begin
        req.re     = 1'b1;
        req.raddr  = '0;
        state_next = crr_pkg::S_LOAD;
      end
      crr_pkg::S_LOAD: begin
        req.re     = !last;
        req.raddr  = site + 10'd1;
        state_next = crr_pkg::S_LAP;
      end
      crr_pkg::S_LAP: begin
        mul_a      = crr_pkg::abs_mag(cfg.a);
        mul_b      = crr_pkg::abs_mag(src_cur.y);
        neg_next   = cfg.a[31] ^ src_cur.y[31];
        clamp_now  = lp1.clamp | lp2.clamp | lp3.clamp | tt.clamp;
        state_next = crr_pkg::S_DY;
      end
      crr_pkg::S_DY: begin
        mul_a      = crr_pkg::abs_mag(cfg.d);
        mul_b      = crr_pkg::abs_mag(lap);
        neg_next   = cfg.d[31] ^ lap[31];
        clamp_now  = qf.clamp | dyv.clamp | n1.clamp | n2.clamp;
        state_next = crr_pkg::S_DX;
      end
      crr_pkg::S_DX: begin
        mul_a      = crr_pkg::abs_mag(src_cur.z);
        mul_b      = crr_pkg::abs_mag(tv);
        neg_next   = src_cur.z[31] ^ tv[31];
        clamp_now  = qf.clamp | dxv.clamp;
        state_next = crr_pkg::S_DZ;
      end
      crr_pkg::S_DZ: begin
        clamp_now  = qf.clamp | dzv.clamp;
        state_next = crr_pkg::S_INC;
      end
      crr_pkg::S_INC: begin
        clamp_now  = ux.clamp | uy.clamp | uz.clamp;
        state_next = crr_pkg::S_MUL_DT;
      end
      crr_pkg::S_MUL_DT: begin
        // The last stage scales the full increment sum, earlier ones the derivative.
        if (stage == 2'd3) begin
          mul_a    = crr_pkg::abs_mag(crr_pkg::tri_get(incn, j));
          neg_next = crr_pkg::tri_get(incn, j) < 0;
        end else begin
          mul_a    = crr_pkg::abs_mag(crr_pkg::tri_get(k, j));
          neg_next = crr_pkg::tri_get(k, j) < 0;
        end
        mul_b      = {15'd0, cfg.dt};
        state_next = crr_pkg::S_QDT;
      end
      crr_pkg::S_QDT: begin
        if (stage == 2'd3) begin
          clamp_now  = qf.clamp;
          state_next = crr_pkg::S_MUL_R6;
        end else begin
          clamp_now  = qf.clamp | su.clamp;
          state_next = (j == 2'd2) ? crr_pkg::S_WRITE : crr_pkg::S_MUL_DT;
        end
      end
      crr_pkg::S_MUL_R6: begin
        mul_a      = crr_pkg::abs_mag(qv) + crr_pkg::R6_BIAS;
        mul_b      = crr_pkg::RECIP6;
        state_next = crr_pkg::S_R6;
      end
      crr_pkg::S_R6: begin
        clamp_now  = su6.clamp;
        state_next = (j == 2'd2) ? crr_pkg::S_WRITE : crr_pkg::S_MUL_DT;
      end
      crr_pkg::S_WRITE: begin
        req.we.inc    = 1'b1;
        req.we.stg    = (stage != 2'd3);
        req.we.osc    = (stage == 2'd3);
        req.waddr     = site;
        req.wdata.inc = incn;
        req.wdata.stg = res;
        req.wdata.osc = res;
        if (!last) begin
          state_next = crr_pkg::S_LOAD;
        end else if (stage == 2'd3 && steps_left == 16'd1) begin
          state_next = crr_pkg::S_IDLE;
        end else begin
          state_next = crr_pkg::S_PRE_LAST;
        end
      end
      default: state_next = crr_pkg::S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mul_neg <= neg_next;
    case (state)
      crr_pkg::S_IDLE: begin
        site       <= '0;
        stage      <= 2'd0;
        j          <= 2'd0;
        steps_left <= cfg.steps;
        len_m1     <= crr_pkg::AW'(len_clamped - 11'd1);
      end
      crr_pkg::S_PRE_FIRST: xl <= src_rd.x;
      crr_pkg::S_LOAD: begin
        cur <= rdata;
        if (site == '0) begin
          x0 <= src_rd.x;
        end
      end
      crr_pkg::S_LAP: begin
        lap <= lp3.val;
        tv  <= tt.val;
      end
      crr_pkg::S_DY: begin
        k.y <= dyv.val;
        nyz <= n2.val;
      end
      crr_pkg::S_DX: k.x <= dxv.val;
      crr_pkg::S_DZ: k.z <= dzv.val;
      crr_pkg::S_INC: begin
        incn <= {uz.val, uy.val, ux.val};
        j    <= 2'd0;
      end
      crr_pkg::S_QDT: begin
        if (stage == 2'd3) begin
          qv <= qf.val;
        end else begin
          res <= crr_pkg::tri_set(res, j, su.val);
          if (j != 2'd2) begin
            j <= j + 2'd1;
          end
        end
      end
      crr_pkg::S_R6: begin
        res <= crr_pkg::tri_set(res, j, su6.val);
        if (j != 2'd2) begin
          j <= j + 2'd1;
        end
      end
      crr_pkg::S_WRITE: begin
        // The old x of this site is the left neighbor of the next one.
        xl <= src_cur.x;
        if (last) begin
          site <= '0;
          if (stage == 2'd3) begin
            stage      <= 2'd0;
            steps_left <= steps_left - 16'd1;
          end else begin
            stage <= stage + 2'd1;
          end
        end else begin
          site <= site + 10'd1;
        end
      end
      default: ;
    endcase
  end

  assign busy      = (state != crr_pkg::S_IDLE);
  assign saturated = flag;

  // The walk never leaves the ring in use.
  a_site_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state != crr_pkg::S_IDLE && state != crr_pkg::S_PRE_LAST) |-> site <= len_m1)
    else $error("site index beyond ring length");

  // The saturation flag is sticky.
  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    flag |=> flag)
    else $error("saturation flag cleared");

  // A site other than the first is loaded only right after the previous write.
  a_load_order: assert property (@(posedge clk) disable iff (rst)
    (state == crr_pkg::S_LOAD && site != '0) |-> $past(state) == crr_pkg::S_WRITE)
    else $error("site loaded out of order");

  // The component counter stays on x, y or z during updates.
  a_comp_range: assert property (@(posedge clk) disable iff (rst)
    (state == crr_pkg::S_QDT || state == crr_pkg::S_R6) |-> j != 2'd3)
    else $error("component index out of range");

endmodule

// File: src/coupled_roessler_ring_rk4.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coupled_roessler_ring_rk4: ring of diffusively coupled Roessler oscillators.
// Load, read and RK4 integration of up to 1024 sites in signed Q16.16.
// ----------------------------------------------------------------------------
// A load transaction writes one site in the cycle it is accepted and the block
// can take a new transaction in the next cycle. A read transaction's result
// appears with done for one cycle, in the cycle after it is accepted; reads
// and loads can be issued back to back. The receiver cannot stall, so the
// result must be captured in that cycle. A run transaction holds busy for
// step_count RK4 steps over the ring length clamped to 3..1024: each step
// makes four passes over the ring, each a neighbor prefetch of the last and
// first sites and then one site after another, paced by the single site-store
// port and the one shared 32x32 multiplier.
// A run with step_count zero does nothing and leaves busy low.
module coupled_roessler_ring_rk4 (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [9:0]         site_index,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               saturated,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  logic [23:0] coeff_a;
  logic [23:0] coeff_b;
  logic [23:0] coeff_c;
  logic [23:0] coupling_d;
  logic [16:0] time_step;
  logic [15:0] step_count;
  logic [10:0] ring_length;

  logic              accept;
  logic              run_go;
  crr_pkg::cfg_t     cfg;
  crr_pkg::mem_req_t host_req;
  crr_pkg::mem_req_t eng_req;
  crr_pkg::mem_req_t mem_req;
  crr_pkg::entry_t   rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_a     <= crr_pkg::RST_COEFF_A;
      coeff_b     <= crr_pkg::RST_COEFF_B;
      coeff_c     <= crr_pkg::RST_COEFF_C;
      coupling_d  <= crr_pkg::RST_COUPLING;
      time_step   <= crr_pkg::RST_DT;
      step_count  <= crr_pkg::RST_STEPS;
      ring_length <= crr_pkg::RST_LEN;
    end else if (cfg_write) begin
      case (cfg_index)
        crr_pkg::REG_COEFF_A:    coeff_a     <= cfg_data;
        crr_pkg::REG_COEFF_B:    coeff_b     <= cfg_data;
        crr_pkg::REG_COEFF_C:    coeff_c     <= cfg_data;
        crr_pkg::REG_COUPLING_D: coupling_d  <= cfg_data;
        crr_pkg::REG_TIME_STEP:  time_step   <= cfg_data[16:0];
        crr_pkg::REG_STEP_COUNT: step_count  <= cfg_data[15:0];
        crr_pkg::REG_RING_LEN:   ring_length <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Coefficients sign-extended to the value format.
  assign cfg.a     = {{8{coeff_a[23]}}, coeff_a};
  assign cfg.b     = {{8{coeff_b[23]}}, coeff_b};
  assign cfg.c     = {{8{coeff_c[23]}}, coeff_c};
  assign cfg.d     = {{8{coupling_d[23]}}, coupling_d};
  assign cfg.dt    = time_step;
  assign cfg.steps = step_count;
  assign cfg.len   = ring_length;

  // Transaction decode.
  assign accept = start && !busy;
  assign run_go = accept && (func == crr_pkg::FUNC_RUN);

  // Host side of the site store: loads write, reads fetch one site.
  always_comb begin
    host_req               = '0;
    host_req.re            = accept && (func == crr_pkg::FUNC_READ);
    host_req.raddr         = site_index;
    host_req.we.osc        = accept && (func == crr_pkg::FUNC_LOAD);
    host_req.waddr         = site_index;
    host_req.wdata.osc.x   = in_x;
    host_req.wdata.osc.y   = in_y;
    host_req.wdata.osc.z   = in_z;
  end

  assign mem_req = busy ? eng_req : host_req;

  crr_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  crr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .run_go    (run_go),
    .cfg       (cfg),
    .rdata     (rdata),
    .req       (eng_req),
    .busy      (busy),
    .saturated (saturated)
  );

  // Read result strobe, registered in the cycle after the read is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept && (func == crr_pkg::FUNC_READ);
    end
  end

  assign out_x = rdata.osc.x;
  assign out_y = rdata.osc.y;
  assign out_z = rdata.osc.z;

  // A result always belongs to a read accepted in the previous cycle.
  a_done_from_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && func == crr_pkg::FUNC_READ))
    else $error("result without a read transaction");

  // A result never overlaps a run, so the store port still holds the read data.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while the ring is integrating");

endmodule
